[rtl/sine_quadrant_reduced_taylor_unit_assert.svh]
// assertion macros used by sine_quadrant_reduced_taylor_unit
`ifndef SINE_QUADRANT_REDUCED_TAYLOR_UNIT_ASSERT_SVH
`define SINE_QUADRANT_REDUCED_TAYLOR_UNIT_ASSERT_SVH
// same-cycle implication, idle while in reset
`define SQT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// plain invariant, checked every cycle out of reset
`define SQT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant failed");
`endif

[rtl/sqtay_pkg.sv]
// ----------------------------------------------------------------------------
// sqtay_pkg
// types, constants and coefficient lookup for the quadrant reduced sine
// ----------------------------------------------------------------------------
`default_nettype none
package sqtay_pkg;

  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
  localparam logic [40:0] HALF_PI_Q40     = 41'h1921FB54443;
  localparam int          WORK_FRAC       = 31;
  localparam int          RED_FRAC        = 40;
  localparam int          T_W             = 34;
  localparam int          N_STEPS         = 6;

  localparam logic signed [T_W-1:0] ONE_Q31     = 34'sd2147483648;
  localparam logic signed [T_W-1:0] SIN_START   = -34'sd54;
  localparam logic signed [T_W-1:0] COS_START   = 34'sd4;

  // sideband that travels with each item through the polynomial steps
  typedef struct packed {
    logic        neg;
    logic        is_cos;
    logic [31:0] r;
    logic [31:0] r2;
  } side_t;

  // addend of horner step idx for the selected polynomial
  function automatic logic signed [T_W-1:0] step_addend(input logic is_cos,
                                                        input logic [2:0] idx);
    logic signed [T_W-1:0] c;
    c = '0;
    if (is_cos) begin
      case (idx)
        3'd0: c = -34'sd592;
        3'd1: c = 34'sd53261;
        3'd2: c = -34'sd2982616;
        3'd3: c = 34'sd89478485;
        3'd4: c = -34'sd1073741824;
        3'd5: c = ONE_Q31;
        default: c = '0;
      endcase
    end else begin
      case (idx)
        3'd0: c = 34'sd5918;
        3'd1: c = -34'sd426088;
        3'd2: c = 34'sd17895697;
        3'd3: c = -34'sd357913941;
        3'd4: c = ONE_Q31;
        3'd5: c = '0;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/sine_quadrant_reduced_taylor_unit.sv]
// ----------------------------------------------------------------------------
// sine_quadrant_reduced_taylor_unit
// q9.22 angle in, saturated q1.30 sine out, fully pipelined
// ----------------------------------------------------------------------------
// depth: 19 register stages from the accepting edge to done:
//   6 reduction stages, 6 horner steps of 2 stages each, one output stage
// throughput: one item per cycle, busy is always low and results cannot be
//   held off; the polynomial chain of 2-stage multiply-add steps sets the depth
// reset: synchronous, clears all valid bits; no results are pending after it
`default_nettype none
`include "sine_quadrant_reduced_taylor_unit_assert.svh"
module sine_quadrant_reduced_taylor_unit #(
  parameter int ANGLE_FRAC_BITS = 22,
  parameter int OUT_FRAC_BITS   = 30
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [31:0]      sine
);
  import sqtay_pkg::*;

  localparam int KW = 32 - ANGLE_FRAC_BITS;
  localparam int KPW = KW + 41;

  // stage signals
  logic             v1, v2, v3, v4, v5, v6;
  logic             n1, n2, n3, n4, n5;
  logic [63:0]      prod1;
  logic [31:0]      m1, m2, m3;
  logic [KW-1:0]    k2;
  logic [KPW-1:0]   kp3;
  logic [1:0]       q3, q4, q5;
  logic             rn4, rn5;
  logic [31:0]      r4, r5;
  logic [63:0]      rsq5;
  logic signed [T_W-1:0] t6;
  side_t            side6;

  logic [31:0]      m_in;
  logic [63:0]      ksum;
  logic [63:0]      diff;
  logic [63:0]      ra;
  logic [63:0]      ra_rnd;
  logic [63:0]      r2_rnd;

  assign busy = 1'b0;
  assign m_in = angle[31] ? 32'(-angle) : angle;

  // stage 1: magnitude times 2/pi
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    prod1 <= 64'(m_in) * 64'(TWO_OVER_PI_Q32);
    m1    <= m_in;
    n1    <= angle[31];
  end

  // stage 2: nearest multiple of pi/2
  assign ksum = (prod1 + (64'd1 << (ANGLE_FRAC_BITS + 31))) >> (ANGLE_FRAC_BITS + 32);
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    k2 <= ksum[KW-1:0];
    m2 <= m1;
    n2 <= n1;
  end

  // stage 3: k times pi/2 in q.40
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    kp3 <= KPW'(k2) * KPW'(HALF_PI_Q40);
    q3  <= k2[1:0];
    m3  <= m2;
    n3  <= n2;
  end

  // stage 4: remainder, sign split off, rounded to q.31
  assign diff   = (64'(m3) << (RED_FRAC - ANGLE_FRAC_BITS)) - 64'(kp3);
  assign ra     = diff[63] ? -diff : diff;
  assign ra_rnd = (ra + (64'd1 << (RED_FRAC - WORK_FRAC - 1))) >> (RED_FRAC - WORK_FRAC);
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    r4  <= ra_rnd[31:0];
    rn4 <= diff[63];
    q4  <= q3;
    n4  <= n3;
  end

  // stage 5: r squared
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    rsq5 <= 64'(r4) * 64'(r4);
    r5   <= r4;
    rn5  <= rn4;
    q5   <= q4;
    n5   <= n4;
  end

  // stage 6: round r2, pick polynomial and final sign
  assign r2_rnd = (rsq5 + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    side6.neg    <= n5 ^ q5[1] ^ (~q5[0] & rn5);
    side6.is_cos <= q5[0];
    side6.r      <= r5;
    side6.r2     <= r2_rnd[31:0];
    t6           <= q5[0] ? COS_START : SIN_START;
  end

  // horner chain; last sine step multiplies by r instead of r2
  logic                  hv [N_STEPS+1];
  logic signed [T_W-1:0] ht [N_STEPS+1];
  side_t                 hs [N_STEPS+1];

  assign hv[0] = v6;
  assign ht[0] = t6;
  assign hs[0] = side6;

  for (genvar j = 0; j < N_STEPS; j++) begin : g_step
    logic [31:0] b;
    assign b = (!hs[j].is_cos && (j == N_STEPS - 1)) ? hs[j].r : hs[j].r2;
    sqtay_horner_step u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (hv[j]),
      .in_t     (ht[j]),
      .in_b     (b),
      .in_add   (step_addend(hs[j].is_cos, 3'(j))),
      .in_side  (hs[j]),
      .out_valid(hv[j+1]),
      .out_t    (ht[j+1]),
      .out_side (hs[j+1])
    );
  end

  // output stage: clamp, round to output format, saturate, sign
  logic signed [T_W-1:0] vclip;
  logic [T_W:0]          u;
  logic [31:0]           umag;
  localparam logic [31:0] OUT_ONE = 32'd1 << OUT_FRAC_BITS;

  assign vclip = ht[N_STEPS][T_W-1] ? '0 : ht[N_STEPS];
  assign u = ((T_W+1)'(vclip) + ((T_W+1)'(1) << (WORK_FRAC - OUT_FRAC_BITS - 1)))
             >> (WORK_FRAC - OUT_FRAC_BITS);
  assign umag = (u > (T_W+1)'(OUT_ONE)) ? OUT_ONE : u[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hv[N_STEPS];
    end
    sine <= hs[N_STEPS].neg ? -$signed(umag) : $signed(umag);
  end

  // checks
  `SQT_ASSERT_IMP(a_out_range, done,
    (sine <= $signed(OUT_ONE)) && (sine >= -$signed(OUT_ONE)))
  `SQT_ASSERT_IMP(a_rem_fits, v5, r5[31] == 1'b0)
  `SQT_ASSERT_IMP(a_r2_le_r, v6, side6.r2 <= side6.r)

endmodule
`default_nettype wire

[rtl/sqtay_horner_step.sv]
// ----------------------------------------------------------------------------
// sqtay_horner_step
// one horner step t = round(t * b) + add, two register stages
// ----------------------------------------------------------------------------
`default_nettype none
module sqtay_horner_step (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic signed [sqtay_pkg::T_W-1:0] in_t,
  input  wire logic        [31:0]               in_b,
  input  wire logic signed [sqtay_pkg::T_W-1:0] in_add,
  input  wire sqtay_pkg::side_t                 in_side,
  output logic                                  out_valid,
  output logic signed [sqtay_pkg::T_W-1:0]      out_t,
  output sqtay_pkg::side_t                      out_side
);
  import sqtay_pkg::*;

  logic                   a_valid;
  logic                   a_sign;
  logic [T_W+31:0]        a_prod;
  logic signed [T_W-1:0]  a_add;
  side_t                  a_side;
  logic signed [T_W-1:0]  neg_t;
  logic [T_W-2:0]         mag;
  logic [T_W+31:0]        rnd;
  logic signed [T_W-1:0]  p;

  // magnitude of t, as the rounding is symmetric about zero
  assign neg_t = -in_t;
  assign mag   = in_t[T_W-1] ? neg_t[T_W-2:0] : in_t[T_W-2:0];

  // stage a: magnitude product
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_sign <= in_t[T_W-1];
    a_prod <= (T_W+32)'(mag) * (T_W+32)'(in_b);
    a_add  <= in_add;
    a_side <= in_side;
  end

  // round half up on magnitude, restore sign
  assign rnd = (a_prod + (T_W+32)'(64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
  assign p   = a_sign ? -$signed(rnd[T_W-1:0]) : $signed(rnd[T_W-1:0]);

  // stage b: accumulate coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_t    <= p + a_add;
    out_side <= a_side;
  end

endmodule
`default_nettype wire
